// ===== rtl/core/cff_pkg.sv =====
// Shared types, codes and microprogram for the complex FIR filter.
package cff_pkg;

    // Default number of complex taps
    localparam int unsigned CFF_TAPS = 64;

    // Field widths fixed by the item format
    localparam int unsigned SMP_W  = 16;
    localparam int unsigned COEF_W = 18;
    localparam int unsigned CIDX_W = 6;
    localparam int unsigned SHF_W  = 6;
    localparam logic [SHF_W-1:0] SHIFT_RST = 6'd17;

    // Configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_SHIFT  = 1'b1;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    // Microprogram address
    typedef logic [3:0] t_upc;

    localparam t_upc U_CLEAR  = 4'd0;
    localparam t_upc U_IDLE   = 4'd1;
    localparam t_upc U_DECODE = 4'd2;
    localparam t_upc U_COEF   = 4'd3;
    localparam t_upc U_FLUSH  = 4'd4;
    localparam t_upc U_LOAD   = 4'd5;
    localparam t_upc U_MAC    = 4'd6;
    localparam t_upc U_DRAINA = 4'd7;
    localparam t_upc U_DRAINB = 4'd8;
    localparam t_upc U_ROUND  = 4'd9;
    localparam t_upc U_EMITF  = 4'd10;
    localparam t_upc U_EMITP  = 4'd11;

    // Jump conditions
    typedef enum logic [2:0] {
        J_NEXT    = 3'd0,  // fall through
        J_ALWAYS  = 3'd1,  // jump to target
        J_NOACC   = 3'd2,  // jump to target unless an item is taken
        J_NOTLAST = 3'd3,  // jump to target until the counter is at its last value
        J_OUTBUSY = 3'd4,  // jump to target while the output register is held, else idle
        J_DECODE  = 3'd5   // multiway on the latched operation
    } t_jc;

    // One control word
    typedef struct packed {
        logic in_rdy;   // take an input item
        logic clr_we;   // zero tap at the counter
        logic coef_we;  // write latched coefficient
        logic flush;    // forget the history
        logic load;     // store sample, start a convolution
        logic issue;    // read one tap/history pair
        logic cnt_inc;  // step the counter
        logic rnd;      // add rounding constant to accumulators
        logic emit_f;   // present filtered result
        logic emit_p;   // present passed-through sample
        t_jc  jc;
        t_upc tgt;
    } t_uop;

    // Status seen by the sequencer
    typedef struct packed {
        logic       acc;       // input transfer this cycle
        logic       last;      // counter at TAPS-1
        logic       out_busy;  // result register full and stalled
        logic       enable;
        logic [1:0] op;
    } t_stat;

    // Microprogram store
    function automatic t_uop uop_rom(input t_upc pc);
        t_uop u;
        u = '0;
        u.jc  = J_NEXT;
        u.tgt = U_IDLE;
        unique case (pc)
            U_CLEAR: begin
                u.clr_we = 1'b1; u.cnt_inc = 1'b1; u.jc = J_NOTLAST; u.tgt = U_CLEAR;
            end
            U_IDLE: begin
                u.in_rdy = 1'b1; u.jc = J_NOACC; u.tgt = U_IDLE;
            end
            U_DECODE: begin
                u.jc = J_DECODE;
            end
            U_COEF: begin
                u.coef_we = 1'b1; u.jc = J_ALWAYS; u.tgt = U_IDLE;
            end
            U_FLUSH: begin
                u.flush = 1'b1; u.jc = J_ALWAYS; u.tgt = U_IDLE;
            end
            U_LOAD: begin
                u.load = 1'b1;
            end
            U_MAC: begin
                u.issue = 1'b1; u.cnt_inc = 1'b1; u.jc = J_NOTLAST; u.tgt = U_MAC;
            end
            U_DRAINA, U_DRAINB: begin
                u.jc = J_NEXT;
            end
            U_ROUND: begin
                u.rnd = 1'b1;
            end
            U_EMITF: begin
                u.emit_f = 1'b1; u.jc = J_OUTBUSY; u.tgt = U_EMITF;
            end
            U_EMITP: begin
                u.emit_p = 1'b1; u.jc = J_OUTBUSY; u.tgt = U_EMITP;
            end
            default: begin
                u.jc = J_ALWAYS; u.tgt = U_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/cff_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module cff_seq
    import cff_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_uop  o_uop
);

    t_upc r_pc;
    t_upc n_pc;
    t_uop w_uop;

    assign w_uop = uop_rom(r_pc);
    assign o_uop = w_uop;

    // Next step
    always_comb begin
        n_pc = r_pc + 4'd1;
        unique case (w_uop.jc)
            J_NEXT:    n_pc = r_pc + 4'd1;
            J_ALWAYS:  n_pc = w_uop.tgt;
            J_NOACC:   n_pc = i_stat.acc ? r_pc + 4'd1 : w_uop.tgt;
            J_NOTLAST: n_pc = i_stat.last ? r_pc + 4'd1 : w_uop.tgt;
            J_OUTBUSY: n_pc = i_stat.out_busy ? w_uop.tgt : U_IDLE;
            J_DECODE: begin
                unique case (i_stat.op)
                    OP_SAMPLE: n_pc = i_stat.enable ? U_LOAD : U_EMITP;
                    OP_COEF:   n_pc = U_COEF;
                    OP_FLUSH:  n_pc = U_FLUSH;
                    default:   n_pc = U_IDLE;
                endcase
            end
            default:   n_pc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/complex_fir_filter.sv =====
// Top level of the complex FIR filter: datapath, memories and handshakes.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_operation, i_sample_*, i_coef_index,
//          |           |                         | i_coef_re, i_coef_im
//  out     | from block| o_out_valid / i_out_stall| o_out_re, o_out_im
//  cfg     | to block  | i_cfg_wr_en             | i_cfg_index, i_cfg_wdata
//
// A filtered sample holds the block through decode, load, one complex multiply-accumulate per
// tap, the DRAINA and DRAINB steps, rounding and emission, where its result is registered;
// each memory has a single read port, used by the tap loop.
// Coefficient and flush items hold it through decode and their own step; a pass-through item
// holds it through decode and its emission step, where its result is registered.
// After reset the tap memory is zeroed tap by tap; no item is taken meanwhile.
// A result waits in the output register; the block still takes the next item, and only
// stalls at the end of a following item while that register is held.
module complex_fir_filter
    import cff_pkg::*;
#(
    parameter int unsigned TAPS = CFF_TAPS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic signed [SMP_W-1:0]  i_sample_re,
    input  logic signed [SMP_W-1:0]  i_sample_im,
    input  logic [CIDX_W-1:0]        i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_re,
    input  logic signed [COEF_W-1:0] i_coef_im,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [SMP_W-1:0]  o_out_re,
    output logic signed [SMP_W-1:0]  o_out_im,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_index,
    input  logic [SHF_W-1:0]         i_cfg_wdata
);

    localparam int unsigned IW = $clog2(TAPS);
    localparam int unsigned XW = ((IW > CIDX_W) ? IW : CIDX_W) + 1;
    localparam int unsigned PW = COEF_W + SMP_W;   // one product
    localparam int unsigned AW = PW + 1 + IW;      // exact accumulator
    localparam int unsigned RW = AW + 1;           // accumulator plus rounding
    localparam logic [SHF_W-1:0] SHIFT_MAX = SHF_W'(AW);
    localparam logic [IW-1:0]    LAST      = IW'(TAPS - 1);

    t_uop  w_uop;
    t_stat w_stat;

    // Configuration
    logic             r_enable;
    logic [SHF_W-1:0] r_shift;

    // Latched item
    logic [1:0]               r_op;
    logic signed [SMP_W-1:0]  r_smp_re, r_smp_im;
    logic [CIDX_W-1:0]        r_cidx;
    logic signed [COEF_W-1:0] r_coef_re, r_coef_im;

    // Counters and history bookkeeping
    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_wpos;
    logic [IW:0]   r_fill;

    // Memories and their read registers
    logic [2*SMP_W-1:0]  hist_mem [TAPS];
    logic [2*COEF_W-1:0] tap_mem  [TAPS];
    logic [2*SMP_W-1:0]  r_hist_q;
    logic [2*COEF_W-1:0] r_tap_q;
    logic                r_hist_ok;
    logic                r_v1, r_v2;

    // Arithmetic
    logic signed [PW-1:0]    r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [AW-1:0]    r_acc_re, r_acc_im;
    logic signed [RW-1:0]    r_rnd_re, r_rnd_im;
    logic signed [SMP_W-1:0] w_xr, w_xi, w_tr, w_ti;
    logic [SHF_W-1:0]        w_s;
    logic [RW-1:0]           w_rc;
    logic signed [RW-1:0]    w_sh_re, w_sh_im;
    logic signed [SMP_W-1:0] w_sat_re, w_sat_im;
    logic signed [COEF_W-1:0] w_hr, w_hi;

    // Output register
    logic                    r_out_vld;
    logic signed [SMP_W-1:0] r_out_re, r_out_im;

    logic                w_acc;
    logic                w_busy;
    logic [XW-1:0]       w_cidx_x;
    logic                w_cidx_ok;
    logic                w_tap_we;
    logic [IW-1:0]       w_tap_addr;
    logic [2*COEF_W-1:0] w_tap_wd;

    // Sequencer
    cff_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uop   (w_uop)
    );

    assign w_acc  = i_in_valid & w_uop.in_rdy;
    assign w_busy = r_out_vld & i_out_stall;

    assign w_stat.acc      = w_acc;
    assign w_stat.last     = (r_cnt == LAST);
    assign w_stat.out_busy = w_busy;
    assign w_stat.enable   = r_enable;
    assign w_stat.op       = r_op;

    assign o_in_stall  = ~w_uop.in_rdy;
    assign o_out_valid = r_out_vld;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_shift  <= SHIFT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_wdata[0];
                CFG_SHIFT:  r_shift  <= i_cfg_wdata;
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op      <= i_operation;
            r_smp_re  <= i_sample_re;
            r_smp_im  <= i_sample_im;
            r_cidx    <= i_coef_index;
            r_coef_re <= i_coef_re;
            r_coef_im <= i_coef_im;
        end
    end

    // Counter, read pointer, write position and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_k    <= '0;
            r_wpos <= '0;
            r_fill <= '0;
        end else begin
            if (w_uop.load) begin
                r_cnt  <= '0;
                r_k    <= r_wpos;
                r_wpos <= (r_wpos == LAST) ? '0 : r_wpos + 1'b1;
                if (r_fill != (IW+1)'(TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else begin
                if (w_uop.cnt_inc) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_uop.issue) begin
                    r_k <= (r_k == '0) ? LAST : r_k - 1'b1;
                end
            end
            if (w_uop.flush) begin
                r_wpos <= '0;
                r_fill <= '0;
            end
        end
    end

    // History memory: entries at or above the fill count read as zero
    always_ff @(posedge i_clk) begin
        if (w_uop.load) begin
            hist_mem[r_wpos] <= {r_smp_re, r_smp_im};
        end
        r_hist_q  <= hist_mem[r_k];
        r_hist_ok <= ({1'b0, r_k} < r_fill);
    end

    // Tap memory: one write port shared by the clearing pass and coefficient items
    assign w_cidx_x   = XW'(r_cidx);
    assign w_cidx_ok  = (w_cidx_x < XW'(TAPS));
    assign w_tap_we   = w_uop.clr_we | (w_uop.coef_we & w_cidx_ok);
    assign w_tap_addr = w_uop.clr_we ? r_cnt : w_cidx_x[IW-1:0];
    assign w_tap_wd   = w_uop.clr_we ? '0 : {r_coef_re, r_coef_im};

    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            tap_mem[w_tap_addr] <= w_tap_wd;
        end
        r_tap_q <= tap_mem[r_cnt];
    end

    // Multiply stage
    assign w_xr = r_hist_ok ? r_hist_q[2*SMP_W-1:SMP_W] : '0;
    assign w_xi = r_hist_ok ? r_hist_q[SMP_W-1:0]       : '0;
    assign w_hr = r_tap_q[2*COEF_W-1:COEF_W];
    assign w_hi = r_tap_q[COEF_W-1:0];
    assign w_tr = w_xr;
    assign w_ti = w_xi;

    always_ff @(posedge i_clk) begin
        r_p_rr <= w_hr * w_tr;
        r_p_ii <= w_hi * w_ti;
        r_p_ri <= w_hr * w_ti;
        r_p_ir <= w_hi * w_tr;
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_uop.issue;
            r_v2 <= r_v1;
        end
    end

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (w_uop.load) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + AW'(r_p_rr) - AW'(r_p_ii);
            r_acc_im <= r_acc_im + AW'(r_p_ri) + AW'(r_p_ir);
        end
    end

    // Rounding: a shift beyond the accumulator width gives the same result as one equal to it
    assign w_s  = (r_shift > SHIFT_MAX) ? SHIFT_MAX : r_shift;
    assign w_rc = (w_s == '0) ? '0 : (RW'(1) << (w_s - 1'b1));

    always_ff @(posedge i_clk) begin
        if (w_uop.rnd) begin
            r_rnd_re <= RW'(r_acc_re) + $signed(w_rc);
            r_rnd_im <= RW'(r_acc_im) + $signed(w_rc);
        end
    end

    // Shift and saturate
    assign w_sh_re = r_rnd_re >>> w_s;
    assign w_sh_im = r_rnd_im >>> w_s;

    always_comb begin
        if (w_sh_re > RW'(32767)) begin
            w_sat_re = 16'sh7FFF;
        end else if (w_sh_re < -RW'(32768)) begin
            w_sat_re = -16'sh8000;
        end else begin
            w_sat_re = w_sh_re[SMP_W-1:0];
        end
        if (w_sh_im > RW'(32767)) begin
            w_sat_im = 16'sh7FFF;
        end else if (w_sh_im < -RW'(32768)) begin
            w_sat_im = -16'sh8000;
        end else begin
            w_sat_im = w_sh_im[SMP_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((w_uop.emit_f | w_uop.emit_p) & ~w_busy) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld & ~i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (~w_busy) begin
            if (w_uop.emit_f) begin
                r_out_re <= w_sat_re;
                r_out_im <= w_sat_im;
            end else if (w_uop.emit_p) begin
                r_out_re <= r_smp_re;
                r_out_im <= r_smp_im;
            end
        end
    end

endmodule
